/* design/euclidean_rhythm_pattern_macros.svh */
// Assertion macros shared by the Euclidean rhythm pattern design.
// Depends on nothing; included by files that carry assertions.
`ifndef EUCLIDEAN_RHYTHM_PATTERN_MACROS_SVH
`define EUCLIDEAN_RHYTHM_PATTERN_MACROS_SVH

// condition checked on every rising clock edge outside reset
`define ERP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that holds in the cycle after a trigger
`define ERP_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

/* design/erp_pkg.sv */
// Package for the Euclidean rhythm pattern generator: widths, default step count, rounds per stage.
// Depends on nothing.
`default_nettype none
package erp_pkg;
	localparam int MAX_STEPS_DEF = 16;
	localparam int MASK_BITS     = 16;
	localparam int CNT_W         = 5;
	// regrouping rounds done in each pipeline stage
	localparam int ROUNDS_PER_STAGE = 2;
endpackage
`default_nettype wire

/* design/erp_round_stage.sv */
// One pipeline stage of the Bjorklund regrouping: ROUNDS_PER_STAGE rounds, then a register.
// Depends on erp_pkg.
`default_nettype none
module erp_round_stage
	import erp_pkg::*;
#(
	parameter int PW = 32,
	parameter int LW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_vld,
	input  wire logic [PW-1:0] in_pat_a,
	input  wire logic [PW-1:0] in_pat_b,
	input  wire logic [LW-1:0] in_len_a,
	input  wire logic [LW-1:0] in_len_b,
	input  wire logic [LW-1:0] in_num_a,
	input  wire logic [LW-1:0] in_num_b,
	input  wire logic [LW-1:0] in_steps,
	input  wire logic          in_direct,
	output logic               out_vld,
	output logic      [PW-1:0] out_pat_a,
	output logic      [PW-1:0] out_pat_b,
	output logic      [LW-1:0] out_len_a,
	output logic      [LW-1:0] out_len_b,
	output logic      [LW-1:0] out_num_a,
	output logic      [LW-1:0] out_num_b,
	output logic      [LW-1:0] out_steps,
	output logic               out_direct
);
	logic [PW-1:0] pa [ROUNDS_PER_STAGE+1];
	logic [PW-1:0] pb [ROUNDS_PER_STAGE+1];
	logic [LW-1:0] la [ROUNDS_PER_STAGE+1];
	logic [LW-1:0] lb [ROUNDS_PER_STAGE+1];
	logic [LW-1:0] na [ROUNDS_PER_STAGE+1];
	logic [LW-1:0] nb [ROUNDS_PER_STAGE+1];

	// regrouping rounds; a round is a no-op once one B group or none is left
	always_comb begin
		pa[0] = in_pat_a; pb[0] = in_pat_b;
		la[0] = in_len_a; lb[0] = in_len_b;
		na[0] = in_num_a; nb[0] = in_num_b;
		for (int r = 0; r < ROUNDS_PER_STAGE; r++) begin
			pa[r+1] = pa[r]; pb[r+1] = pb[r];
			la[r+1] = la[r]; lb[r+1] = lb[r];
			na[r+1] = na[r]; nb[r+1] = nb[r];
			if (nb[r] > LW'(1)) begin
				pa[r+1] = pa[r] | (pb[r] << la[r]);
				la[r+1] = la[r] + lb[r];
				if (nb[r] > na[r]) begin
					nb[r+1] = nb[r] - na[r];
					na[r+1] = na[r];
				end else begin
					nb[r+1] = na[r] - nb[r];
					na[r+1] = nb[r];
					pb[r+1] = pa[r];
					lb[r+1] = la[r];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pat_a  <= pa[ROUNDS_PER_STAGE];
			out_pat_b  <= pb[ROUNDS_PER_STAGE];
			out_len_a  <= la[ROUNDS_PER_STAGE];
			out_len_b  <= lb[ROUNDS_PER_STAGE];
			out_num_a  <= na[ROUNDS_PER_STAGE];
			out_num_b  <= nb[ROUNDS_PER_STAGE];
			out_steps  <= in_steps;
			out_direct <= in_direct;
		end
	end
endmodule
`default_nettype wire

/* design/euclidean_rhythm_pattern.sv */
// Top level of the Euclidean rhythm pattern generator (pipelined Bjorklund).
// Depends on erp_pkg, erp_round_stage and euclidean_rhythm_pattern_macros.svh.
//
//  channel | signals                                      | direction
//  input   | in_valid, in_ready, pulse_count, step_count  | into block
//  output  | out_valid, out_ready, pattern_mask           | out of block
//
// Words pass the setup, round and output registers; one enters per cycle unless stalled.
// Depth is set by the regrouping rounds (at most MAX_STEPS-1, two per stage).
// A stall on out_ready freezes the whole pipeline; nothing is lost or repeated.
// arst_n clears only the valid bits; payload registers hold no reset.
`default_nettype none
`include "euclidean_rhythm_pattern_macros.svh"
module euclidean_rhythm_pattern
	import erp_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CNT_W-1:0]     pulse_count,
	input  wire logic [CNT_W-1:0]     step_count,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [MASK_BITS-1:0]      pattern_mask
);
	localparam int PW = MAX_STEPS;
	localparam int LW = $clog2(MAX_STEPS + 1);
	localparam int ROUND_STAGES = (MAX_STEPS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;
	localparam int NS = ROUND_STAGES + 1;

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage chain signals; index 0 is the setup register
	logic          v  [NS];
	logic [PW-1:0] pa [NS];
	logic [PW-1:0] pb [NS];
	logic [LW-1:0] la [NS];
	logic [LW-1:0] lb [NS];
	logic [LW-1:0] na [NS];
	logic [LW-1:0] nb [NS];
	logic [LW-1:0] st [NS];
	logic          dr [NS];

	// setup: clamp step count, sort out the special cases
	logic [LW-1:0] steps_c;
	logic [LW-1:0] pulses_c;
	logic          zero_c;
	logic          full_c;
	always_comb begin
		if ({1'b0, step_count} > (CNT_W+1)'(MAX_STEPS))
			steps_c = LW'(MAX_STEPS);
		else
			steps_c = LW'(step_count);
		zero_c   = (step_count == '0) || (pulse_count == '0);
		full_c   = ({1'b0, pulse_count} >= (CNT_W+1)'(steps_c));
		pulses_c = full_c ? steps_c : LW'(pulse_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (adv) begin
			v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa[0] <= PW'(1);
			pb[0] <= '0;
			la[0] <= LW'(1);
			lb[0] <= LW'(1);
			na[0] <= zero_c ? '0 : pulses_c;
			nb[0] <= (zero_c || full_c) ? '0 : LW'(steps_c - pulses_c);
			st[0] <= zero_c ? '0 : steps_c;
			dr[0] <= zero_c || full_c;
		end
	end

	for (genvar g = 0; g < ROUND_STAGES; g++) begin : g_stage
		erp_round_stage #(.PW(PW), .LW(LW)) u_stage (
			.clk, .arst_n, .adv,
			.in_vld(v[g]), .in_pat_a(pa[g]), .in_pat_b(pb[g]),
			.in_len_a(la[g]), .in_len_b(lb[g]), .in_num_a(na[g]), .in_num_b(nb[g]),
			.in_steps(st[g]), .in_direct(dr[g]),
			.out_vld(v[g+1]), .out_pat_a(pa[g+1]), .out_pat_b(pb[g+1]),
			.out_len_a(la[g+1]), .out_len_b(lb[g+1]),
			.out_num_a(na[g+1]), .out_num_b(nb[g+1]),
			.out_steps(st[g+1]), .out_direct(dr[g+1])
		);
	end

	// direct result for the empty and full cases: the low na bits set; lowmask keeps the low st bits
	logic [PW-1:0] flat;
	logic [PW-1:0] lowmask;
	always_comb begin
		flat = '0;
		for (int i = 0; i < PW; i++) begin
			if (LW'(i) < na[NS-1])
				flat[i] = 1'b1;
		end
		if (!dr[NS-1])
			flat = '0;
		for (int k = 0; k < PW; k++)
			lowmask[k] = (LW'(k) < st[NS-1]);
	end

	// the group layout: replicate the A pattern na times, then B nb times
	logic [PW-1:0] layout_a;
	logic [PW-1:0] layout_b;
	logic [LW-1:0] a_end;
	always_comb begin
		layout_a = '0;
		layout_b = '0;
		a_end    = LW'(na[NS-1] * la[NS-1]);
		for (int i = 0; i < PW; i++) begin
			if (LW'(i) < na[NS-1])
				layout_a = layout_a | (pa[NS-1] << (LW'(i) * la[NS-1]));
			if (LW'(i) < nb[NS-1])
				layout_b = layout_b | (pb[NS-1] << (a_end + LW'(i) * lb[NS-1]));
		end
	end

	logic [PW-1:0] res;
	assign res = (dr[NS-1] ? flat : (layout_a | layout_b)) & lowmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pattern_mask <= MASK_BITS'({{MASK_BITS{1'b0}}, res});
		end
	end

	`ERP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pattern_mask), "result changed under stall")
	`ERP_ASSERT(a_ready_rule, in_ready == (!out_valid || out_ready), "in_ready wrong")
	`ERP_ASSERT_NEXT(a_valid_advance, v[0] && adv, v[1], "setup word not advanced")
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for euclidean_rhythm_pattern: random and directed count pairs, checked
// against an in-bench Bjorklund predictor. Depends on erp_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_top;
	import erp_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0] pulses;
		logic [CNT_W-1:0] steps;
	} count_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CNT_W-1:0] pulse_count = '0;
	logic [CNT_W-1:0] step_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [MASK_BITS-1:0] pattern_mask;

	count_pair_t pending_pairs[$];
	logic [MASK_BITS-1:0] expected_masks[$];
	bit stimulus_done = 1'b0;
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_cycles = 0;
	int stall_phase = 0;

	euclidean_rhythm_pattern u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pulse_count(pulse_count), .step_count(step_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.pattern_mask(pattern_mask)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bjorklund regrouping with one pattern, length and count per group kind
	function automatic logic [MASK_BITS-1:0] euclid_pattern(input int unsigned pulses,
			input int unsigned steps);
		longint unsigned pat_a, pat_b, joined, result;
		int unsigned len_a, len_b, num_a, num_b, pairs, pos, joined_len;
		if (steps > MAX_STEPS_DEF)
			steps = MAX_STEPS_DEF;
		if (steps == 0 || pulses == 0)
			return '0;
		if (pulses >= steps)
			return MASK_BITS'((64'd1 << steps) - 64'd1);
		pat_a = 1; len_a = 1; num_a = pulses;
		pat_b = 0; len_b = 1; num_b = steps - pulses;
		for (int guard = 0; guard < 64 && num_b > 1; guard++) begin
			joined = pat_a | (pat_b << len_a);
			joined_len = len_a + len_b;
			pairs = (num_a < num_b) ? num_a : num_b;
			if (num_b > num_a) begin
				num_b = num_b - pairs;
			end else begin
				// leftover A groups become the remainder
				num_b = num_a - pairs;
				pat_b = pat_a;
				len_b = len_a;
			end
			pat_a = joined;
			len_a = joined_len;
			num_a = pairs;
		end
		result = 0;
		pos = 0;
		for (int unsigned i = 0; i < num_a && pos < 63; i++) begin
			result |= pat_a << pos;
			pos += len_a;
		end
		for (int unsigned i = 0; i < num_b && pos < 63; i++) begin
			result |= pat_b << pos;
			pos += len_b;
		end
		result &= (64'd1 << steps) - 64'd1;
		return MASK_BITS'(result);
	endfunction

	function automatic count_pair_t make_pair(input int unsigned p, input int unsigned s);
		count_pair_t w;
		w.pulses = CNT_W'(p);
		w.steps = CNT_W'(s);
		return w;
	endfunction

	// stimulus: directed corners, then random pairs (mostly in range, some wide)
	initial begin
		int unsigned p, s;
		pending_pairs.push_back(make_pair(0, 0));
		pending_pairs.push_back(make_pair(0, 16));
		pending_pairs.push_back(make_pair(5, 0));
		pending_pairs.push_back(make_pair(16, 16));
		pending_pairs.push_back(make_pair(20, 8));
		pending_pairs.push_back(make_pair(31, 31));
		pending_pairs.push_back(make_pair(3, 31));
		pending_pairs.push_back(make_pair(1, 16));
		pending_pairs.push_back(make_pair(15, 16));
		pending_pairs.push_back(make_pair(3, 8));
		pending_pairs.push_back(make_pair(5, 8));
		pending_pairs.push_back(make_pair(5, 13));
		pending_pairs.push_back(make_pair(7, 16));
		pending_pairs.push_back(make_pair(1, 1));
		pending_pairs.push_back(make_pair(1, 2));
		pending_pairs.push_back(make_pair(9, 16));
		pending_pairs.push_back(make_pair(2, 5));
		pending_pairs.push_back(make_pair(10, 17));
		for (int n = 0; n < 900; n++) begin
			if ($urandom_range(9) < 8) begin
				s = $urandom_range(16);
				p = $urandom_range(16);
			end else begin
				s = $urandom_range(31);
				p = $urandom_range(31);
			end
			pending_pairs.push_back(make_pair(p, s));
		end
	end

	// reset once, then release
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: bursts of words with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_masks.push_back(euclid_pattern(pulse_count, step_count));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					count_pair_t w;
					w = pending_pairs.pop_front();
					in_valid <= 1'b1;
					pulse_count <= w.pulses;
					step_count <= w.steps;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(20);
						gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
					end
				end else begin
					in_valid <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
		end
	end

	// receiver: one long hold-off early on, then a rotating stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			hold_cycles <= hold_cycles + 1;
			stall_phase <= (stall_phase + 1) % 97;
			if (hold_cycles >= 40 && hold_cycles < 240)
				out_ready <= 1'b0;
			else if (stall_phase < 30)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(3) != 0);
		end
	end

	// monitor: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_masks.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time,
					pattern_mask);
				errors <= errors + 1;
			end else begin
				logic [MASK_BITS-1:0] want;
				want = expected_masks.pop_front();
				if (want !== pattern_mask) begin
					$display("%0t: pattern_mask mismatch, expected %h, actual %h", $time,
						want, pattern_mask);
					errors <= errors + 1;
				end
			end
		end
	end

	// end of run: drain, then settle for the pipeline latency
	initial begin
		wait (stimulus_done);
		wait (expected_masks.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_masks.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
